FILE: src/two_channel_pwm_generator_assert.svh
// assertion macros for the two-channel pwm generator
`ifndef TWO_CHANNEL_PWM_GENERATOR_ASSERT_SVH
`define TWO_CHANNEL_PWM_GENERATOR_ASSERT_SVH

// condition holds at every clock edge outside reset
`define TCPWM_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("%m: invariant violated");

// consequence holds in the cycle after the antecedent
`define TCPWM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: sequence violated");

`endif

FILE: src/tcpwm_pkg.sv
// types, register indexes and divisor helpers for the pwm generator
package tcpwm_pkg;

   localparam int CNT_W   = 16;
   localparam int PRE_W   = 11;
   localparam int SEL_W   = 3;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 16;

   // largest total division, 2^7 * 14
   localparam logic [PRE_W-1:0] MAX_DIV = PRE_W'(1792);

   typedef enum logic [IDX_W-1:0] {
      REG_CLK_DIV_SEL = 3'd0,
      REG_HSP_DIV_SEL = 3'd1,
      REG_PERIOD      = 3'd2,
      REG_COMPARE_A   = 3'd3,
      REG_COMPARE_B   = 3'd4,
      REG_FREEZE      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [SEL_W-1:0] clk_div_sel;
      logic [SEL_W-1:0] hsp_div_sel;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] compare_a;
      logic [CNT_W-1:0] compare_b;
      logic             freeze;
   } cfg_type;

   typedef struct packed {
      logic             stage_move;
      logic [PRE_W-1:0] prescale;
      logic [CNT_W-1:0] time_base;
   } status_type;

   localparam logic [3:0] HSP_DIV [8] = '{
      4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12, 4'd14
   };

   function automatic logic [PRE_W-1:0] total_div(
      input logic [SEL_W-1:0] clk_sel,
      input logic [SEL_W-1:0] hsp_sel
   );
      logic [PRE_W-1:0] base;
      base = {{(PRE_W-4){1'b0}}, HSP_DIV[hsp_sel]};
      return base << clk_sel;
   endfunction

endpackage

FILE: src/tcpwm_if.sv
// handshake channel interfaces: tick requests, pwm responses, register writes
interface tcpwm_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface tcpwm_rsp_if;
   logic        valid;
   logic        ready;
   logic        pwm_a;
   logic        pwm_b;
   logic [15:0] count;

   modport source (output valid, output pwm_a, output pwm_b, output count, input ready);
   modport sink   (input valid, input pwm_a, input pwm_b, input count, output ready);
endinterface

interface tcpwm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/tcpwm_csr.sv
// configuration register file with write decoder
module tcpwm_csr (
   input  logic              clock,
   input  logic              reset,
   tcpwm_csr_if.sink         csr_bus,
   output tcpwm_pkg::cfg_type cfg
);
   import tcpwm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_CLK_DIV_SEL: cfg_in.clk_div_sel = csr_bus.data[SEL_W-1:0];
            REG_HSP_DIV_SEL: cfg_in.hsp_div_sel = csr_bus.data[SEL_W-1:0];
            REG_PERIOD:      cfg_in.period      = csr_bus.data[CNT_W-1:0];
            REG_COMPARE_A:   cfg_in.compare_a   = csr_bus.data[CNT_W-1:0];
            REG_COMPARE_B:   cfg_in.compare_b   = csr_bus.data[CNT_W-1:0];
            REG_FREEZE:      cfg_in.freeze      = csr_bus.data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{clk_div_sel: '0, hsp_div_sel: '0, period: '0,
                     compare_a: '0, compare_b: '0, freeze: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/tcpwm_core.sv
// tick input stage, prescaler, time base, compare logic and response register
module tcpwm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tcpwm_pkg::cfg_type   cfg,
   tcpwm_req_if.sink            req_bus,
   tcpwm_rsp_if.source          rsp_bus,
   output tcpwm_pkg::status_type status
);
   import tcpwm_pkg::*;

   // input stage
   logic             stage_valid_ff, stage_valid_in;
   logic             stage_tick_ff;
   // time base state
   logic [PRE_W-1:0] prescale_ff, prescale_in;
   logic [CNT_W-1:0] time_base_ff, time_base_in;
   logic             level_a_ff, level_a_in;
   logic             level_b_ff, level_b_in;
   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pwm_a_ff;
   logic             rsp_pwm_b_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic             out_free;
   logic             stage_move;
   logic             advance;
   logic             wrap_pre;
   logic [PRE_W-1:0] divisor;
   logic [CNT_W-1:0] next_count;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign stage_move    = stage_valid_ff && out_free;
   assign req_bus.ready = !stage_valid_ff || out_free;

   assign stage_valid_in = (req_bus.valid && req_bus.ready) ||
                           (stage_valid_ff && !stage_move);
   assign rsp_valid_in   = stage_move || (rsp_valid_ff && !rsp_bus.ready);

   assign divisor  = total_div(cfg.clk_div_sel, cfg.hsp_div_sel);
   assign advance  = stage_move && stage_tick_ff && !cfg.freeze;
   assign wrap_pre = ({1'b0, prescale_ff} + (PRE_W+1)'(1)) >= {1'b0, divisor};

   // a count at or past period wraps to zero
   assign next_count = (time_base_ff >= cfg.period) ? '0 : time_base_ff + CNT_W'(1);

   always_comb begin
      prescale_in  = prescale_ff;
      time_base_in = time_base_ff;
      level_a_in   = level_a_ff;
      level_b_in   = level_b_ff;
      if (advance) begin
         if (wrap_pre) begin
            prescale_in  = '0;
            time_base_in = next_count;
            // clear wins over set on the same count
            if (next_count == '0) begin
               level_a_in = 1'b1;
               level_b_in = 1'b1;
            end
            if (next_count == cfg.compare_a) level_a_in = 1'b0;
            if (next_count == cfg.compare_b) level_b_in = 1'b0;
         end else begin
            prescale_in = prescale_ff + PRE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prescale_ff    <= '0;
         time_base_ff   <= '0;
         level_a_ff     <= 1'b0;
         level_b_ff     <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         prescale_ff    <= prescale_in;
         time_base_ff   <= time_base_in;
         level_a_ff     <= level_a_in;
         level_b_ff     <= level_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stage_tick_ff <= req_bus.tick;
      end
      if (stage_move) begin
         rsp_pwm_a_ff <= level_a_in;
         rsp_pwm_b_ff <= level_b_in;
         rsp_count_ff <= time_base_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pwm_a = rsp_pwm_a_ff;
   assign rsp_bus.pwm_b = rsp_pwm_b_ff;
   assign rsp_bus.count = rsp_count_ff;

   assign status.stage_move = stage_move;
   assign status.prescale   = prescale_ff;
   assign status.time_base  = time_base_ff;

endmodule

FILE: src/two_channel_pwm_generator.sv
// top level of the two-channel up-count pwm generator
//
// req_bus carries one base-clock tick per transaction (tick=0 lets no time
// pass). every request yields exactly one transaction on rsp_bus with the
// levels of outputs a and b and the time base count after that tick.
// csr_bus writes the registers: 0 clk_div_sel, 1 hsp_div_sel, 2 period,
// 3 compare_a, 4 compare_b, 5 freeze; other indexes are dropped. csr_bus
// is always ready; write only while no request is in flight.
// an accepted request is captured in the input register, then moves to the
// response register, which drives rsp_bus.
// throughput: one request per cycle while rsp_bus does not stall; the
// prescaler/time base state registers update through combinational logic.
// when rsp_bus stalls, the response register holds and the input register
// keeps one more request; req_bus.ready drops only when both are full.
// reset (synchronous) clears the pipeline, the counters and both outputs,
// zeroes the other configuration registers and sets freeze, so ticks report a stopped counter
// until freeze is written to 0.
module two_channel_pwm_generator (
   input  logic       clock,
   input  logic       reset,
   tcpwm_req_if.sink  req_bus,
   tcpwm_rsp_if.source rsp_bus,
   tcpwm_csr_if.sink  csr_bus
);
   import tcpwm_pkg::*;

   cfg_type    cfg;
   status_type status;

   tcpwm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   tcpwm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .status  (status)
   );

`include "two_channel_pwm_generator_assert.svh"

   `TCPWM_ASSERT_ALWAYS(a_prescale_range, status.prescale < MAX_DIV)
   `TCPWM_ASSERT_NEXT(a_frozen_hold, status.stage_move && cfg.freeze, $stable(status.time_base) && $stable(status.prescale))
   `TCPWM_ASSERT_NEXT(a_count_step, status.stage_move, status.time_base == '0 || $stable(status.time_base) || status.time_base == $past(status.time_base) + CNT_W'(1))
   `TCPWM_ASSERT_NEXT(a_idle_hold, !status.stage_move, $stable(status.time_base) && $stable(status.prescale))

endmodule
